// File: sv/fixed_length_frame_deframer_defines.svh
// Assertion macros for the frame deframer checker.
// Used by fld_checker.sv; assumes signals clk and rst_n in scope.
`ifndef FIXED_LENGTH_FRAME_DEFRAMER_DEFINES_SVH
`define FIXED_LENGTH_FRAME_DEFRAMER_DEFINES_SVH

// Check a property on every clock edge outside reset
`define FLD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included
`define FLD_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: sv/fld_pkg.sv
// Shared types, constants and helpers for the fixed-length frame deframer.
// No dependencies.
`default_nettype none

package fld_pkg;

    localparam int FRAME_BYTES_DEF = 43;
    localparam int COUNT_W         = 32;
    localparam int ADDR_W          = 4;
    localparam int DATA_W          = 32;

    // Frame layout
    localparam int MODE_OFF  = 2;
    localparam int WORD_OFF  = 19;
    localparam int WORD_CNT  = 4;
    localparam int PICK_CNT  = 1 + 4 * WORD_CNT;

    // Register indexes
    localparam logic [1:0] REG_HEAD_FIRST  = 2'd0;
    localparam logic [1:0] REG_HEAD_SECOND = 2'd1;
    localparam logic [1:0] REG_TAIL_FIRST  = 2'd2;
    localparam logic [1:0] REG_TAIL_SECOND = 2'd3;

    typedef struct packed {
        logic [7:0] head_first;
        logic [7:0] head_second;
        logic [7:0] tail_first;
        logic [7:0] tail_second;
    } cfg_t;

    // Sequencer to cell row and result register
    typedef struct packed {
        logic load;
        logic shift;
        logic out_load;
        logic out_frame;
    } chain_ctrl_t;

    // Cell row and result register to sequencer
    typedef struct packed {
        logic head_hit;
        logic tail_hit;
        logic out_free;
    } chain_stat_t;

    function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
        return (v == {COUNT_W{1'b1}}) ? v : v + COUNT_W'(1);
    endfunction

endpackage

`default_nettype wire

// File: sv/fld_cell.sv
// One byte cell of the deframer window row.
// Loads a received byte or takes its right neighbor's byte on a shift.
`default_nettype none

module fld_cell (
    input  wire logic       clk,
    input  wire logic       load,
    input  wire logic       shift,
    input  wire logic [7:0] din,
    input  wire logic [7:0] nbr,
    output logic      [7:0] q
);

    logic [7:0] q_reg;

    // Load the new byte, or advance toward the front
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            q_reg <= din;
        end
        else if (shift)
        begin
            q_reg <= nbr;
        end
    end

    assign q = q_reg;

endmodule

`default_nettype wire

// File: sv/fld_regs.sv
// APB configuration registers of the frame deframer.
// Depends on fld_pkg.
`default_nettype none

module fld_regs
    import fld_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready,
    output cfg_t                   cfg
);

    cfg_t       cfg_reg;
    logic [1:0] idx;
    logic [7:0] rd_byte;

    assign idx    = paddr[3:2];
    assign pready = 1'b1;

    // Write on the access phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (idx)
                REG_HEAD_FIRST:  cfg_reg.head_first  <= pwdata[7:0];
                REG_HEAD_SECOND: cfg_reg.head_second <= pwdata[7:0];
                REG_TAIL_FIRST:  cfg_reg.tail_first  <= pwdata[7:0];
                REG_TAIL_SECOND: cfg_reg.tail_second <= pwdata[7:0];
                default:         cfg_reg <= cfg_reg;
            endcase
        end
    end

    // Read back
    always_comb
    begin
        unique case (idx)
            REG_HEAD_FIRST:  rd_byte = cfg_reg.head_first;
            REG_HEAD_SECOND: rd_byte = cfg_reg.head_second;
            REG_TAIL_FIRST:  rd_byte = cfg_reg.tail_first;
            REG_TAIL_SECOND: rd_byte = cfg_reg.tail_second;
            default:         rd_byte = '0;
        endcase
    end

    assign prdata = {{(DATA_W - 8){1'b0}}, rd_byte};
    assign cfg    = cfg_reg;

endmodule

`default_nettype wire

// File: sv/fld_seq.sv
// Sequencer of the frame deframer: window fill, scan steps and counters.
// Depends on fld_pkg; drives the cell row through chain_ctrl_t.
`default_nettype none

module fld_seq
    import fld_pkg::*;
#(
    parameter int FRAME_BYTES = FRAME_BYTES_DEF,
    parameter int FILL_W      = $clog2(FRAME_BYTES + 1)
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  chain_stat_t             stat,
    output chain_ctrl_t             ctrl,
    output logic [FILL_W-1:0]       fill,
    output logic [COUNT_W-1:0]      seen_count,
    output logic [COUNT_W-1:0]      drop_count,
    output logic [COUNT_W-1:0]      reject_count
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(FRAME_BYTES);
    localparam logic [FILL_W-1:0] FILL_TWO  = FILL_W'(2);

    logic [1:0]         state_reg,  state_next;
    logic [FILL_W-1:0]  fill_reg,   fill_next;
    logic [COUNT_W-1:0] seen_reg,   seen_next;
    logic [COUNT_W-1:0] drop_reg,   drop_next;
    logic [COUNT_W-1:0] reject_reg, reject_next;
    logic               pend_reg,   pend_next;
    logic               done;
    logic               done_frame;

    always_comb
    begin
        state_next  = state_reg;
        fill_next   = fill_reg;
        seen_next   = seen_reg;
        drop_next   = drop_reg;
        reject_next = reject_reg;
        pend_next   = pend_reg;
        ctrl        = '0;
        done        = 1'b0;
        done_frame  = 1'b0;

        unique case (state_reg)
            // Take a byte and append it at the fill point unless the row is full
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    seen_next = sat_inc(seen_reg);
                    if (fill_reg < FILL_FULL)
                    begin
                        ctrl.load = 1'b1;
                        fill_next = fill_reg + FILL_W'(1);
                    end
                    state_next = ST_SCAN;
                end
            end
            // One scan step: stop, emit, or drop the front byte
            ST_SCAN:
            begin
                if (fill_reg < FILL_TWO)
                begin
                    done = 1'b1;
                end
                else if (stat.head_hit && (fill_reg != FILL_FULL))
                begin
                    done = 1'b1;
                end
                else if (stat.head_hit && stat.tail_hit)
                begin
                    done       = 1'b1;
                    done_frame = 1'b1;
                    fill_next  = '0;
                end
                else
                begin
                    if (stat.head_hit)
                    begin
                        reject_next = sat_inc(reject_reg);
                    end
                    drop_next  = sat_inc(drop_reg);
                    ctrl.shift = 1'b1;
                    fill_next  = fill_reg - FILL_W'(1);
                end
            end
            // Wait for the result register
            ST_DONE:
            begin
                done       = 1'b1;
                done_frame = pend_reg;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Hand the result over, or hold it until the register frees
        if (done)
        begin
            if (stat.out_free)
            begin
                ctrl.out_load  = 1'b1;
                ctrl.out_frame = done_frame;
                state_next     = ST_IDLE;
            end
            else
            begin
                pend_next  = done_frame;
                state_next = ST_DONE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            fill_reg   <= '0;
            seen_reg   <= '0;
            drop_reg   <= '0;
            reject_reg <= '0;
            pend_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            fill_reg   <= fill_next;
            seen_reg   <= seen_next;
            drop_reg   <= drop_next;
            reject_reg <= reject_next;
            pend_reg   <= pend_next;
        end
    end

    assign in_ready     = (state_reg == ST_IDLE);
    assign fill         = fill_reg;
    assign seen_count   = seen_reg;
    assign drop_count   = drop_reg;
    assign reject_count = reject_reg;

endmodule

`default_nettype wire

// File: sv/fixed_length_frame_deframer.sv
// Fixed-length frame deframer: bytes enter a row of FRAME_BYTES cells that
// shifts toward the front one byte per cycle while dropping, as the sequencer hunts
// for the two-byte header and checks the trailer once a full frame sits in the row.
// Each byte is accepted and then scanned; every byte dropped from the front of the
// row adds one scan step, so one item takes one more scan step than the bytes it
// causes to be dropped, at most FRAME_BYTES - 1 of them. No new byte is accepted
// until the item is done. When the previous result is still waiting in the output
// register at the end of the scan, the item holds in a wait state until the
// receiver takes that result. There is no clearing pass after reset.
// Depends on fld_pkg, fld_cell, fld_regs and fld_seq.
`default_nettype none

module fixed_length_frame_deframer
    import fld_pkg::*;
#(
    parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [ADDR_W-1:0]  paddr,
    input  wire logic [DATA_W-1:0]  pwdata,
    output logic      [DATA_W-1:0]  prdata,
    output logic                    pready,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [7:0]         byte_in,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic                    frame_valid,
    output logic      [7:0]         mode,
    output logic      [31:0]        yaw_word,
    output logic      [31:0]        yaw_rate_word,
    output logic      [31:0]        pitch_word,
    output logic      [31:0]        pitch_rate_word,
    output logic      [COUNT_W-1:0] total_count,
    output logic      [COUNT_W-1:0] discard_count,
    output logic      [COUNT_W-1:0] bad_count
);

    localparam int FILL_W = $clog2(FRAME_BYTES + 1);

    cfg_t               cfg;
    chain_ctrl_t        ctrl;
    chain_stat_t        stat;
    logic [FILL_W-1:0]  fill;
    logic [COUNT_W-1:0] seen_count;
    logic [COUNT_W-1:0] drop_count;
    logic [COUNT_W-1:0] reject_count;

    logic [7:0]  cell_q [FRAME_BYTES];
    logic [7:0]  pick   [PICK_CNT];
    logic [31:0] word_w [WORD_CNT];

    logic               out_valid_reg;
    logic               frame_valid_reg;
    logic [7:0]         mode_reg;
    logic [31:0]        word_reg [WORD_CNT];
    logic [COUNT_W-1:0] total_reg;
    logic [COUNT_W-1:0] discard_reg;
    logic [COUNT_W-1:0] bad_reg;

    fld_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    fld_seq #(
        .FRAME_BYTES (FRAME_BYTES),
        .FILL_W      (FILL_W)
    ) u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .stat         (stat),
        .ctrl         (ctrl),
        .fill         (fill),
        .seen_count   (seen_count),
        .drop_count   (drop_count),
        .reject_count (reject_count)
    );

    // Row of window cells, front at index 0
    for (genvar i = 0; i < FRAME_BYTES; i++)
    begin : g_cell
        logic [7:0] nbr;
        if (i == FRAME_BYTES - 1)
        begin : g_last
            assign nbr = '0;
        end
        else
        begin : g_mid
            assign nbr = cell_q[i + 1];
        end
        fld_cell u_cell (
            .clk   (clk),
            .load  (ctrl.load && (fill == FILL_W'(i))),
            .shift (ctrl.shift),
            .din   (byte_in),
            .nbr   (nbr),
            .q     (cell_q[i])
        );
    end

    // Header at the front, trailer at the last two cells
    assign stat.head_hit = (cell_q[0] == cfg.head_first) && (cell_q[1] == cfg.head_second);
    assign stat.tail_hit = (cell_q[FRAME_BYTES - 2] == cfg.tail_first) &&
                           (cell_q[FRAME_BYTES - 1] == cfg.tail_second);
    assign stat.out_free = !out_valid_reg || out_ready;

    // Pick the mode byte and word bytes; offsets past the frame read as zero
    for (genvar j = 0; j < PICK_CNT; j++)
    begin : g_pick
        localparam int OFF = (j == 0) ? MODE_OFF : WORD_OFF + j - 1;
        if (OFF < FRAME_BYTES)
        begin : g_in
            assign pick[j] = cell_q[OFF];
        end
        else
        begin : g_out
            assign pick[j] = '0;
        end
    end

    // Assemble little-endian words
    for (genvar k = 0; k < WORD_CNT; k++)
    begin : g_word
        assign word_w[k] = {pick[1 + 4*k + 3], pick[1 + 4*k + 2],
                            pick[1 + 4*k + 1], pick[1 + 4*k]};
    end

    // Result valid: set on load, drop when taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctrl.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (ctrl.out_load)
        begin
            frame_valid_reg <= ctrl.out_frame;
            mode_reg        <= ctrl.out_frame ? pick[0] : '0;
            for (int k = 0; k < WORD_CNT; k++)
            begin
                word_reg[k] <= ctrl.out_frame ? word_w[k] : '0;
            end
            total_reg   <= seen_count;
            discard_reg <= drop_count;
            bad_reg     <= reject_count;
        end
    end

    assign out_valid       = out_valid_reg;
    assign frame_valid     = frame_valid_reg;
    assign mode            = mode_reg;
    assign yaw_word        = word_reg[0];
    assign yaw_rate_word   = word_reg[1];
    assign pitch_word      = word_reg[2];
    assign pitch_rate_word = word_reg[3];
    assign total_count     = total_reg;
    assign discard_count   = discard_reg;
    assign bad_count       = bad_reg;

endmodule

`default_nettype wire

// File: sv/fld_checker.sv
// Port-level checker for the frame deframer, bound to the top level.
// Depends on fld_pkg and fixed_length_frame_deframer_defines.svh.
`default_nettype none

`include "fixed_length_frame_deframer_defines.svh"

module fld_checker
    import fld_pkg::*;
(
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               pready,
    input wire logic               out_valid,
    input wire logic               out_ready,
    input wire logic               frame_valid,
    input wire logic [7:0]         mode,
    input wire logic [31:0]        yaw_word,
    input wire logic [31:0]        yaw_rate_word,
    input wire logic [31:0]        pitch_word,
    input wire logic [31:0]        pitch_rate_word,
    input wire logic [COUNT_W-1:0] total_count,
    input wire logic [COUNT_W-1:0] discard_count,
    input wire logic [COUNT_W-1:0] bad_count
);

    // A stalled result holds
    `FLD_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(total_count) && $stable(frame_valid), "result changed while stalled")

    // No frame means all frame fields are zero
    `FLD_ASSERT(a_zero_fields, out_valid && !frame_valid |-> mode == 8'd0 && yaw_word == 32'd0 && yaw_rate_word == 32'd0 && pitch_word == 32'd0 && pitch_rate_word == 32'd0, "non-frame result carries data")

    // Dropped bytes were seen, and every rejected frame dropped a byte
    `FLD_ASSERT(a_count_order, out_valid |-> discard_count <= total_count && bad_count <= discard_count, "counters out of order")

    // Nothing is offered during reset
    `FLD_ASSERT_ALWAYS(a_reset_quiet, !rst_n |-> !out_valid && pready, "output active in reset")

endmodule

bind fixed_length_frame_deframer fld_checker u_fld_checker (.*);

`default_nettype wire
